// File: rtl/rpcs_pkg.sv
`default_nettype none
package rpcs_pkg;

  typedef enum logic [1:0] {
    OP_BUTTON = 2'd0,
    OP_TICK   = 2'd1,
    OP_REPLY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_READ   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_POS     = 2'd1,
    PH_TRAILER = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    REG_POS_MIN   = 3'd0,
    REG_POS_MAX   = 3'd1,
    REG_CODE_HOME = 3'd2,
    REG_CODE_POS  = 3'd3,
    REG_CODE_SPD  = 3'd4,
    REG_CODE_STAT = 3'd5
  } reg_e;

  localparam logic [7:0] FRAME_START   = 8'hFF;
  localparam logic [7:0] REPLY_HEADER  = 8'hFE;
  localparam logic [7:0] REPLY_TRAILER = 8'hFD;
  localparam logic [7:0] POS_STEP      = 8'd10;
  localparam logic [7:0] POS_TOP       = 8'd255;

  localparam int unsigned JOB_DEPTH = 4;

  // sequencer steps of the back end
  localparam logic [3:0] STEP_F0     = 4'd0;
  localparam logic [3:0] STEP_F1     = 4'd4;
  localparam logic [3:0] STEP_READ   = 4'd8;
  localparam logic [3:0] STEP_STATUS = 4'd9;

  typedef struct packed {
    logic [7:0] pos_min;
    logic [7:0] pos_max;
    logic [7:0] code_home;
    logic [7:0] code_pos;
    logic [7:0] code_speed;
    logic [7:0] code_status;
  } cfg_t;

  // one classified item, as handed from front to back
  typedef struct packed {
    logic       f0_valid;
    logic [7:0] f0_code;
    logic [7:0] f0_arg;
    logic       f1_valid;
    logic [7:0] f1_code;
    logic       read;
    logic       ready;
    logic       error;
  } job_t;

endpackage
`default_nettype wire

// File: rtl/rpcs_front.sv
`default_nettype none
module rpcs_front import rpcs_pkg::*; #(
  parameter int unsigned BUTTON_LOCKOUT_US  = 200000,
  parameter int unsigned STATUS_INTERVAL_US = 300000,
  parameter int unsigned SPEED_INTERVAL_US  = 350000,
  parameter int unsigned INITIAL_TARGET     = 100
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        accept_i,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] now_us_i,
  input  wire logic [2:0]  button_mask_i,
  input  wire logic        transmit_idle_i,
  input  wire logic [7:0]  speed_sample_i,
  input  wire logic [7:0]  reply_byte_i,
  output job_t             job_o
);

  localparam logic [31:0] LockoutLim = 32'(BUTTON_LOCKOUT_US);
  localparam logic [31:0] StatusLim  = 32'(STATUS_INTERVAL_US);
  localparam logic [31:0] SpeedLim   = 32'(SPEED_INTERVAL_US);
  localparam logic [31:0] ReadLim    = 32'(STATUS_INTERVAL_US / 2);
  localparam logic [7:0]  InitTarget = 8'(INITIAL_TARGET);

  logic [7:0]  target_q, target_d, sent_q, sent_d, rpos_q, rpos_d;
  logic        rvalid_q, rvalid_d, home_q, home_d, rdiss_q, rdiss_d;
  logic        ready_q, ready_d, error_q, error_d;
  logic [31:0] stat_t_q, stat_t_d, spd_t_q, spd_t_d;
  logic [31:0] seen_q [3];
  logic [31:0] seen_d [3];
  phase_e      phase_q, phase_d;

  logic [1:0]  btn;
  logic        btn_hit;
  logic [31:0] btn_delta, spd_delta, stat_delta;
  logic [8:0]  up_sum;
  logic        spd_fire, stat_fire;

  always_comb begin
    btn_hit = 1'b1;
    if (button_mask_i[0]) begin
      btn = 2'd0;
    end else if (button_mask_i[1]) begin
      btn = 2'd1;
    end else if (button_mask_i[2]) begin
      btn = 2'd2;
    end else begin
      btn     = 2'd0;
      btn_hit = 1'b0;
    end
  end

  assign btn_delta  = now_us_i - seen_q[btn];
  assign spd_delta  = now_us_i - spd_t_q;
  assign stat_delta = now_us_i - stat_t_q;
  assign up_sum     = {1'b0, target_q} + {1'b0, POS_STEP};
  assign spd_fire   = spd_delta > SpeedLim;
  assign stat_fire  = stat_delta > StatusLim;

  always_comb begin
    target_d = target_q;
    sent_d   = sent_q;
    rpos_d   = rpos_q;
    rvalid_d = rvalid_q;
    home_d   = home_q;
    rdiss_d  = rdiss_q;
    ready_d  = ready_q;
    error_d  = error_q;
    stat_t_d = stat_t_q;
    spd_t_d  = spd_t_q;
    seen_d   = seen_q;
    phase_d  = phase_q;
    job_o    = '0;

    case (op_e'(operation_i))
      OP_BUTTON: begin
        if (btn_hit) begin
          seen_d[btn] = now_us_i;
          if (btn_delta > LockoutLim) begin
            case (btn)
              2'd0: begin
                if (target_q > cfg_i.pos_min) begin
                  target_d = (target_q >= POS_STEP) ? target_q - POS_STEP : 8'd0;
                  error_d  = 1'b0;
                end else begin
                  error_d = 1'b1;
                end
              end
              2'd1: begin
                if (target_q < cfg_i.pos_max) begin
                  target_d = up_sum[8] ? POS_TOP : up_sum[7:0];
                  error_d  = 1'b0;
                end else begin
                  error_d = 1'b1;
                end
              end
              default: begin
                home_d   = 1'b1;
                target_d = cfg_i.pos_max;
                error_d  = 1'b0;
              end
            endcase
            ready_d = rvalid_q && (target_d == rpos_q);
          end
        end
      end
      OP_TICK: begin
        if (transmit_idle_i) begin
          if (home_q) begin
            home_d         = 1'b0;
            job_o.f0_valid = 1'b1;
            job_o.f0_code  = cfg_i.code_home;
          end else if (target_q != sent_q) begin
            sent_d         = target_q;
            job_o.f0_valid = 1'b1;
            job_o.f0_code  = cfg_i.code_pos;
            job_o.f0_arg   = target_q;
          end else begin
            if (spd_fire) begin
              spd_t_d        = now_us_i;
              job_o.f0_valid = 1'b1;
              job_o.f0_code  = cfg_i.code_speed;
              job_o.f0_arg   = speed_sample_i;
            end
            if (stat_fire) begin
              // fresh status time: the read check below is skipped on this tick
              stat_t_d       = now_us_i;
              job_o.f1_valid = 1'b1;
              job_o.f1_code  = cfg_i.code_status;
              rdiss_d        = 1'b0;
            end else if (!rdiss_q && (stat_delta > ReadLim)) begin
              job_o.read = 1'b1;
              rdiss_d    = 1'b1;
            end
          end
        end
      end
      OP_REPLY: begin
        case (phase_q)
          PH_HEADER: begin
            if (reply_byte_i == REPLY_HEADER) phase_d = PH_POS;
          end
          PH_POS: begin
            rpos_d   = reply_byte_i;
            rvalid_d = 1'b1;
            phase_d  = PH_TRAILER;
          end
          default: begin
            if (reply_byte_i == REPLY_TRAILER) ready_d = (target_q == rpos_q);
            phase_d = PH_HEADER;
          end
        endcase
      end
      default: ;
    endcase

    job_o.ready = ready_d;
    job_o.error = error_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= InitTarget;
      sent_q   <= '0;
      rpos_q   <= '0;
      rvalid_q <= 1'b0;
      home_q   <= 1'b0;
      rdiss_q  <= 1'b0;
      ready_q  <= 1'b0;
      error_q  <= 1'b0;
      stat_t_q <= '0;
      spd_t_q  <= '0;
      seen_q   <= '{default: '0};
      phase_q  <= PH_HEADER;
    end else if (accept_i) begin
      target_q <= target_d;
      sent_q   <= sent_d;
      rpos_q   <= rpos_d;
      rvalid_q <= rvalid_d;
      home_q   <= home_d;
      rdiss_q  <= rdiss_d;
      ready_q  <= ready_d;
      error_q  <= error_d;
      stat_t_q <= stat_t_d;
      spd_t_q  <= spd_t_d;
      seen_q   <= seen_d;
      phase_q  <= phase_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rpcs_job_fifo.sv
`default_nettype none
module rpcs_job_fifo import rpcs_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire job_t wdata_i,
  output logic      full_o,
  input  wire logic rd_i,
  output job_t      rdata_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
      if (do_rd) rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/rpcs_back.sv
`default_nettype none
module rpcs_back import rpcs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t job_i,
  input  wire logic job_empty_i,
  output logic      job_pop_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output logic [1:0] kind_o,
  output logic [7:0] tx_byte_o,
  output logic       ready_led_o,
  output logic       error_led_o,
  output logic       last_of_run_o
);

  logic       started_q;
  logic [3:0] step_q, cur_step, nxt_step;
  logic       out_valid_q;
  logic       load;
  logic [1:0] kind_d;
  logic [7:0] byte_d;

  // first step of a fresh job, else continue where we left off
  always_comb begin
    if (started_q) begin
      cur_step = step_q;
    end else if (job_i.f0_valid) begin
      cur_step = STEP_F0;
    end else if (job_i.f1_valid) begin
      cur_step = STEP_F1;
    end else if (job_i.read) begin
      cur_step = STEP_READ;
    end else begin
      cur_step = STEP_STATUS;
    end
  end

  always_comb begin
    nxt_step = cur_step + 4'd1;
    if (nxt_step == STEP_F1 && !job_i.f1_valid) nxt_step = STEP_READ;
    if (nxt_step == STEP_READ && !job_i.read) nxt_step = STEP_STATUS;
  end

  always_comb begin
    kind_d = KIND_TX;
    byte_d = '0;
    if (cur_step == STEP_STATUS) begin
      kind_d = KIND_STATUS;
    end else if (cur_step == STEP_READ) begin
      kind_d = KIND_READ;
    end else begin
      case (cur_step[1:0])
        2'd0:    byte_d = FRAME_START;
        2'd1:    byte_d = cur_step[2] ? job_i.f1_code : job_i.f0_code;
        2'd2:    byte_d = cur_step[2] ? 8'd0 : job_i.f0_arg;
        default: byte_d = 8'd0;
      endcase
    end
  end

  assign load      = !job_empty_i && (!out_valid_q || pop_i);
  assign job_pop_o = load && (cur_step == STEP_STATUS);
  assign empty_o   = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      step_q      <= STEP_F0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (cur_step == STEP_STATUS) begin
          started_q <= 1'b0;
        end else begin
          started_q <= 1'b1;
          step_q    <= nxt_step;
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o        <= kind_d;
      tx_byte_o     <= byte_d;
      ready_led_o   <= job_i.ready;
      error_led_o   <= job_i.error;
      last_of_run_o <= (cur_step == STEP_STATUS);
    end
  end

endmodule
`default_nettype wire

// File: rtl/remote_position_command_scheduler.sv
// Channel    Handshake               Payload
// ---------  ----------------------  ---------------------------------------------------
// input      push / full             operation_i, now_us_i, button_mask_i,
//                                    transmit_idle_i, speed_sample_i, reply_byte_i
// result     empty / pop             kind_o, tx_byte_o, ready_led_o, error_led_o,
//                                    last_of_run_o
// config     cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Cycles: the front end classifies an item and updates all state in the cycle it is
//   taken, so items enter one per cycle while the job queue has room.
// The back end sequencer emits one result per cycle while pop stays high, 1 to 9 per item; a job
//   leaves the queue with its status result. A first result passes the queue, then the output register.
// Reset is immediate, no clearing pass; config writes are always ready.
// Stalls: pop low holds the output register; the front keeps taking items until the
//   JOB_DEPTH-entry queue fills, then full rises.
`default_nettype none
module remote_position_command_scheduler import rpcs_pkg::*; #(
  parameter int unsigned BUTTON_LOCKOUT_US  = 200000,
  parameter int unsigned STATUS_INTERVAL_US = 300000,
  parameter int unsigned SPEED_INTERVAL_US  = 350000,
  parameter int unsigned INITIAL_TARGET     = 100
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // input item channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] now_us_i,
  input  wire logic [2:0]  button_mask_i,
  input  wire logic        transmit_idle_i,
  input  wire logic [7:0]  speed_sample_i,
  input  wire logic [7:0]  reply_byte_i,
  // result item channel
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [7:0]       tx_byte_o,
  output logic             ready_led_o,
  output logic             error_led_o,
  output logic             last_of_run_o
);

  cfg_t cfg_q;
  job_t job_in, job_head;
  logic accept, job_empty, job_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // config registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_min     <= 8'd0;
      cfg_q.pos_max     <= 8'd200;
      cfg_q.code_home   <= 8'd1;
      cfg_q.code_pos    <= 8'd2;
      cfg_q.code_speed  <= 8'd3;
      cfg_q.code_status <= 8'd4;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_POS_MIN:   cfg_q.pos_min     <= cfg_data_i;
        REG_POS_MAX:   cfg_q.pos_max     <= cfg_data_i;
        REG_CODE_HOME: cfg_q.code_home   <= cfg_data_i;
        REG_CODE_POS:  cfg_q.code_pos    <= cfg_data_i;
        REG_CODE_SPD:  cfg_q.code_speed  <= cfg_data_i;
        REG_CODE_STAT: cfg_q.code_status <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: lockouts, target tracking, tick scheduling, reply parsing
  rpcs_front #(
    .BUTTON_LOCKOUT_US (BUTTON_LOCKOUT_US),
    .STATUS_INTERVAL_US(STATUS_INTERVAL_US),
    .SPEED_INTERVAL_US (SPEED_INTERVAL_US),
    .INITIAL_TARGET    (INITIAL_TARGET)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .operation_i    (operation_i),
    .now_us_i       (now_us_i),
    .button_mask_i  (button_mask_i),
    .transmit_idle_i(transmit_idle_i),
    .speed_sample_i (speed_sample_i),
    .reply_byte_i   (reply_byte_i),
    .job_o          (job_in)
  );

  // decouples classification from byte-by-byte emission
  rpcs_job_fifo #(
    .DEPTH(JOB_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (accept),
    .wdata_i(job_in),
    .full_o (full),
    .rd_i   (job_pop),
    .rdata_o(job_head),
    .empty_o(job_empty)
  );

  // back: expands a job into frame bytes, read request and closing status
  rpcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_head),
    .job_empty_i  (job_empty),
    .job_pop_o    (job_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .kind_o       (kind_o),
    .tx_byte_o    (tx_byte_o),
    .ready_led_o  (ready_led_o),
    .error_led_o  (error_led_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule
`default_nettype wire

// File: tb/sched_check_pkg.sv
`timescale 1ns / 100ps
package sched_check_pkg;
  import rpcs_pkg::*;

  localparam int unsigned LOCKOUT_US      = 200000;
  localparam int unsigned STATUS_US       = 300000;
  localparam int unsigned SPEED_US        = 350000;
  localparam logic [7:0]  START_TARGET    = 8'd100;

  typedef struct packed {
    op_e         op;
    logic [31:0] now;
    logic [2:0]  mask;
    logic        idle;
    logic [7:0]  speed;
    logic [7:0]  rbyte;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       ready;
    logic       error;
    logic       last;
  } result_t;

  class sched_scoreboard;
    cfg_t        cfg;
    logic [7:0]  target;
    logic [7:0]  sent;
    logic [7:0]  reply_pos;
    logic        reply_valid;
    logic        home_pending;
    logic        read_issued;
    logic        ready_lvl;
    logic        error_lvl;
    logic [31:0] status_time;
    logic [31:0] speed_time;
    logic [31:0] seen_time [3];
    phase_e      parse_phase;
    result_t     run_q[$];       // results of the item in hand
    result_t     expected_q[$];
    int          fails;

    function new();
      cfg = '{pos_min: 8'd0, pos_max: 8'd200, code_home: 8'd1, code_pos: 8'd2,
              code_speed: 8'd3, code_status: 8'd4};
      target       = START_TARGET;
      sent         = '0;
      reply_pos    = '0;
      reply_valid  = 1'b0;
      home_pending = 1'b0;
      read_issued  = 1'b0;
      ready_lvl    = 1'b0;
      error_lvl    = 1'b0;
      status_time  = '0;
      speed_time   = '0;
      foreach (seen_time[b]) seen_time[b] = '0;
      parse_phase  = PH_HEADER;
      fails        = 0;
    endfunction

    function void set_reg(reg_e idx, logic [7:0] v);
      case (idx)
        REG_POS_MIN:   cfg.pos_min = v;
        REG_POS_MAX:   cfg.pos_max = v;
        REG_CODE_HOME: cfg.code_home = v;
        REG_CODE_POS:  cfg.code_pos = v;
        REG_CODE_SPD:  cfg.code_speed = v;
        REG_CODE_STAT: cfg.code_status = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      fails++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void refresh_ready();
      ready_lvl = reply_valid && (target == reply_pos);
    endfunction

    function void emit(kind_e k, logic [7:0] b);
      run_q.push_back('{kind: k, data: b, ready: 1'b0, error: 1'b0, last: 1'b0});
    endfunction

    function void emit_frame(logic [7:0] code, logic [7:0] arg);
      emit(KIND_TX, FRAME_START);
      emit(KIND_TX, code);
      emit(KIND_TX, arg);
      emit(KIND_TX, 8'd0);
    endfunction

    function void press(int b, logic [31:0] now);
      logic [31:0] dt;
      dt = now - seen_time[b];
      seen_time[b] = now;
      if (dt <= LOCKOUT_US) return;
      case (b)
        0: begin
          if (target > cfg.pos_min) begin
            target = (target >= POS_STEP) ? target - POS_STEP : 8'd0;
            error_lvl = 1'b0;
          end else begin
            error_lvl = 1'b1;
          end
        end
        1: begin
          if (target < cfg.pos_max) begin
            target = (target > POS_TOP - POS_STEP) ? POS_TOP : target + POS_STEP;
            error_lvl = 1'b0;
          end else begin
            error_lvl = 1'b1;
          end
        end
        default: begin
          home_pending = 1'b1;
          target = cfg.pos_max;
          error_lvl = 1'b0;
        end
      endcase
      refresh_ready();
    endfunction

    function void tick(item_t it);
      logic [31:0] dt;
      if (!it.idle) return;
      if (home_pending) begin
        home_pending = 1'b0;
        emit_frame(cfg.code_home, 8'd0);
        return;
      end
      if (target != sent) begin
        sent = target;
        emit_frame(cfg.code_pos, target);
        return;
      end
      dt = it.now - speed_time;
      if (dt > SPEED_US) begin
        speed_time = it.now;
        emit_frame(cfg.code_speed, it.speed);
      end
      dt = it.now - status_time;
      if (dt > STATUS_US) begin
        status_time = it.now;
        emit_frame(cfg.code_status, 8'd0);
        read_issued = 1'b0;
      end
      dt = it.now - status_time;
      if (!read_issued && dt > STATUS_US / 2) begin
        emit(KIND_READ, 8'd0);
        read_issued = 1'b1;
      end
    endfunction

    function void parse(logic [7:0] b);
      case (parse_phase)
        PH_HEADER: if (b == REPLY_HEADER) parse_phase = PH_POS;
        PH_POS: begin
          reply_pos   = b;
          reply_valid = 1'b1;
          parse_phase = PH_TRAILER;
        end
        default: begin
          if (b == REPLY_TRAILER) refresh_ready();
          parse_phase = PH_HEADER;
        end
      endcase
    endfunction

    function void note_item(item_t it);
      run_q.delete();
      case (it.op)
        OP_BUTTON: begin
          if (it.mask[0]) press(0, it.now);
          else if (it.mask[1]) press(1, it.now);
          else if (it.mask[2]) press(2, it.now);
        end
        OP_TICK:  tick(it);
        OP_REPLY: parse(it.rbyte);
        default: ;
      endcase
      emit(KIND_STATUS, 8'd0);
      // LEDs carry the levels after the item on every result
      foreach (run_q[k]) begin
        run_q[k].ready = ready_lvl;
        run_q[k].error = error_lvl;
        run_q[k].last  = (k == run_q.size() - 1);
        expected_q.push_back(run_q[k]);
      end
    endfunction

    task check_result(logic [1:0] kind, logic [7:0] data, logic ready,
                      logic error, logic last);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h", kind, data));
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind || data !== want.data || ready !== want.ready ||
          error !== want.error || last !== want.last)
        report($sformatf("got kind %0d byte %02h rdy %b err %b last %b, want %0d %02h %b %b %b",
                         kind, data, ready, error, last,
                         want.kind, want.data, want.ready, want.error, want.last));
    endtask
  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import rpcs_pkg::*;
  import sched_check_pkg::*;

  // Every input is held at a known value from time zero.
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_valid = 1'b0;
  reg_e        cfg_index = REG_POS_MIN;
  logic [7:0]  cfg_data  = '0;
  logic        cfg_ready;
  logic        push      = 1'b0;
  logic        full;
  item_t       item      = '0;
  logic        pop       = 1'b0;
  logic        empty;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        ready_led;
  logic        error_led;
  logic        last_of_run;

  sched_scoreboard sb;

  // sender state: burst counter and the running microsecond clock of the items
  int          burst_left = 0;
  logic [31:0] cur_now    = '0;

  always #5 clk_i = ~clk_i;

  remote_position_command_scheduler u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push           (push),
    .full           (full),
    .operation_i    (item.op),
    .now_us_i       (item.now),
    .button_mask_i  (item.mask),
    .transmit_idle_i(item.idle),
    .speed_sample_i (item.speed),
    .reply_byte_i   (item.rbyte),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind),
    .tx_byte_o      (tx_byte),
    .ready_led_o    (ready_led),
    .error_led_o    (error_led),
    .last_of_run_o  (last_of_run)
  );

  // Drive one item; push stays high across a burst, and a gap opens
  // whenever a burst runs out. The scoreboard learns of the item at the
  // edge that takes it.
  task automatic send_item(input item_t it);
    @(negedge clk_i);
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (push) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
    end
    burst_left--;
    item <= it;
    push <= 1'b1;
    do @(posedge clk_i); while (full !== 1'b0);
    sb.note_item(it);
  endtask

  // Fields the operation does not use still get random values, so every
  // input bit toggles.
  task automatic send(op_e op, logic [2:0] mask, logic idle, logic [7:0] val);
    item_t it;
    it.op    = op;
    it.now   = cur_now;
    it.mask  = mask;
    it.idle  = idle;
    it.speed = (op == OP_TICK) ? val : 8'($urandom);
    it.rbyte = (op == OP_REPLY) ? val : 8'($urandom);
    send_item(it);
  endtask

  // Time steps: mostly below the lockout, some past the intervals, some
  // repeats of the same microsecond and rare jumps anywhere (wraps included).
  task automatic advance();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) cur_now += 32'($urandom_range(0, 120000));
    else if (pick < 90) cur_now += 32'($urandom_range(150000, 400000));
    else if (pick >= 97) cur_now = $urandom;
  endtask

  // One unit of random stimulus: a tick, a button event, a reply frame
  // (mostly well formed, often matching the target so the ready LED lights),
  // or noise.
  task automatic random_unit(output int n_sent);
    int         pick;
    logic [7:0] hdr;
    logic [7:0] pos;
    logic [7:0] trl;
    pick   = $urandom_range(0, 99);
    n_sent = 1;
    advance();
    if (pick < 35) begin
      send(OP_TICK, 3'($urandom), $urandom_range(0, 4) != 0, 8'($urandom));
    end else if (pick < 62) begin
      send(OP_BUTTON, 3'($urandom), 1'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      hdr = ($urandom_range(0, 19) == 0) ? 8'($urandom) : REPLY_HEADER;
      pos = ($urandom_range(0, 9) < 7) ? sb.target : 8'($urandom);
      trl = ($urandom_range(0, 6) == 0) ? 8'($urandom) : REPLY_TRAILER;
      send(OP_REPLY, 3'($urandom), 1'($urandom), hdr);
      send(OP_REPLY, 3'($urandom), 1'($urandom), pos);
      send(OP_REPLY, 3'($urandom), 1'($urandom), trl);
      n_sent = 3;
    end else if ($urandom_range(0, 1) == 0) begin
      send(OP_NONE, 3'($urandom), 1'($urandom), 8'($urandom));
    end else begin
      send(OP_REPLY, 3'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  // Config writes; only issued once the block has drained.
  task automatic write_reg(reg_e idx, logic [7:0] v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Drop push and wait until every expected result has come out.
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Result side: pop follows its own pattern: runs of always-ready, random
  // stalls, and long stalls.
  initial begin : result_sink
    int mode;
    int run_len;
    int stall;
    mode    = 0;
    run_len = 0;
    stall   = 0;
    forever begin
      @(negedge clk_i);
      if (run_len == 0) begin
        mode    = $urandom_range(0, 2);
        run_len = $urandom_range(10, 60);
      end
      run_len--;
      if (mode == 0) begin
        pop <= 1'b1;
      end else if (mode == 1) begin
        pop <= ($urandom_range(0, 2) != 0);
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 12);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Every popped result goes against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_result(kind, tx_byte, ready_led, error_led, last_of_run);
  end

  initial begin : stimulus
    int          n;
    int          count;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [31:0] codes;
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset config.
    // target 100 differs from sent 0: position frame first
    cur_now = 32'd0;
    send(OP_TICK, 3'd0, 1'b1, 8'h80);
    // nothing due yet, status only; then a tick while the bus is busy
    send(OP_TICK, 3'd0, 1'b1, 8'h80);
    send(OP_TICK, 3'd7, 1'b0, 8'h7F);
    // left exactly at the lockout is blocked, one past it steps down
    cur_now = 32'd200000;
    send(OP_BUTTON, 3'd1, 1'b0, 8'h00);
    cur_now = 32'd400001;
    send(OP_BUTTON, 3'd1, 1'b0, 8'h00);
    // empty mask, then all buttons at once (left wins, still locked out)
    send(OP_BUTTON, 3'd0, 1'b1, 8'hFF);
    cur_now = 32'd400002;
    send(OP_BUTTON, 3'd7, 1'b0, 8'h00);
    // right beats home; then home alone
    cur_now = 32'd700000;
    send(OP_BUTTON, 3'd6, 1'b0, 8'h00);
    cur_now = 32'd700100;
    send(OP_BUTTON, 3'd4, 1'b0, 8'h00);
    // home frame goes alone, then the position frame for the new target
    send(OP_TICK, 3'd0, 1'b1, 8'h55);
    send(OP_TICK, 3'd0, 1'b1, 8'h55);
    // speed and status both due
    cur_now = 32'd1000000;
    send(OP_TICK, 3'd0, 1'b1, 8'hFF);
    // half a status interval later: read request, once
    cur_now = 32'd1150001;
    send(OP_TICK, 3'd0, 1'b1, 8'h00);
    send(OP_TICK, 3'd0, 1'b1, 8'h00);
    // good reply frame matching the target lights ready
    send(OP_REPLY, 3'd0, 1'b0, REPLY_HEADER);
    send(OP_REPLY, 3'd0, 1'b0, 8'd200);
    send(OP_REPLY, 3'd0, 1'b0, REPLY_TRAILER);
    // stray byte while awaiting header; frame with a bad trailer
    send(OP_REPLY, 3'd0, 1'b0, 8'h00);
    send(OP_REPLY, 3'd0, 1'b0, REPLY_HEADER);
    send(OP_REPLY, 3'd0, 1'b0, 8'd5);
    send(OP_REPLY, 3'd0, 1'b0, 8'h00);
    // right at the upper limit: error LED on, ready refreshed off
    cur_now = 32'd1400000;
    send(OP_BUTTON, 3'd2, 1'b1, 8'h00);
    // unused operation code only reports status
    send(OP_NONE, 3'd5, 1'b1, 8'hAA);
    settle();

    // Random phases, each under its own config; the first three hit the
    // extremes (full range, inverted limits, a max below one step).
    for (int ph = 0; ph < 5; ph++) begin
      codes = $urandom;
      case (ph)
        0: begin
          lo    = 8'd0;
          hi    = 8'd245;
          codes = {8'hFF, 8'h00, 8'hFE, 8'hFD};
        end
        1: begin
          lo = 8'd255;
          hi = 8'd0;
        end
        2: begin
          lo = 8'd0;
          hi = 8'd5;
        end
        3: begin
          lo      = 8'($urandom);
          hi      = 8'($urandom_range(0, 245));
          cur_now = 32'hFFF8_0000;  // walk across the 32-bit wrap
        end
        default: begin
          lo = 8'($urandom_range(0, 120));
          hi = 8'($urandom_range(121, 245));
        end
      endcase
      write_reg(REG_POS_MIN, lo);
      write_reg(REG_POS_MAX, hi);
      write_reg(REG_CODE_HOME, codes[31:24]);
      write_reg(REG_CODE_POS, codes[23:16]);
      write_reg(REG_CODE_SPD, codes[15:8]);
      write_reg(REG_CODE_STAT, codes[7:0]);
      count = 0;
      while (count < 25) begin
        random_unit(n);
        count += n;
      end
      settle();
    end

    repeat (20) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every item at its worst,
  // every result through the longest stall).
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
